// File: rtl/pcnms_pkg.sv
// pcnms_pkg: shared types and fixed field widths for the per-class box suppression block
// no dependencies
package pcnms_pkg;

	localparam int SCORE_W     = 16;
	localparam int CLASS_W     = 5;
	localparam int LIMIT_W     = 16;
	localparam int KIDX_W      = 6;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd19661;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_INIT,
		ST_SORT_SCAN,
		ST_SORT_WRITE,
		ST_I_READ,
		ST_I_CHECK,
		ST_A_WAIT,
		ST_J_READ,
		ST_J_CHECK,
		ST_B_TEST,
		ST_IOU_WAIT,
		ST_EMIT_READ,
		ST_EMIT_IDX,
		ST_EMIT_BOX,
		ST_EMIT_OUT
	} state_t;

endpackage

// File: rtl/pcnms_ram.sv
// pcnms_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pcnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/pcnms_iou.sv
// pcnms_iou: four-stage pipelined integer iou threshold test for two inclusive-corner boxes
// depends on pcnms_pkg for the threshold width
module pcnms_iou
	import pcnms_pkg::*;
#(
	parameter int CW = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [LIMIT_W-1:0] limit,
	input  logic [4*CW-1:0]    box_a,
	input  logic [4*CW-1:0]    box_b,
	output logic               done,
	output logic               hit
);

	localparam int DW   = CW + 2;
	localparam int PW   = 2 * DW;
	localparam int UW   = PW + 2;
	localparam int CMPW = UW + LIMIT_W + 2;

	logic signed [DW-1:0] al, at, ar, ab, bl, bt, br, bb;
	logic signed [DW-1:0] iw_raw, ih_raw;
	logic signed [DW-1:0] iw_s1, ih_s1, wa_s1, ha_s1, wb_s1, hb_s1;
	logic signed [PW-1:0] inter_s2, area_a_s2, area_b_s2;
	logic signed [UW-1:0] uni_s3, inter_s3;
	logic                 v_s1, v_s2, v_s3;
	logic signed [CMPW-1:0] lhs, rhs;

	function automatic logic signed [DW-1:0] ext(input logic [CW-1:0] v);
		return {{2{v[CW-1]}}, v};
	endfunction

	assign al = ext(box_a[CW-1:0]);
	assign at = ext(box_a[2*CW-1:CW]);
	assign ar = ext(box_a[3*CW-1:2*CW]);
	assign ab = ext(box_a[4*CW-1:3*CW]);
	assign bl = ext(box_b[CW-1:0]);
	assign bt = ext(box_b[2*CW-1:CW]);
	assign br = ext(box_b[3*CW-1:2*CW]);
	assign bb = ext(box_b[4*CW-1:3*CW]);

	// overlap extents, clamped at zero
	assign iw_raw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl) + DW'(1);
	assign ih_raw = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt) + DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1     <= iw_raw[DW-1] ? '0 : iw_raw;
		ih_s1     <= ih_raw[DW-1] ? '0 : ih_raw;
		wa_s1     <= ar - al + DW'(1);
		ha_s1     <= ab - at + DW'(1);
		wb_s1     <= br - bl + DW'(1);
		hb_s1     <= bb - bt + DW'(1);
		inter_s2  <= iw_s1 * ih_s1;
		area_a_s2 <= wa_s1 * ha_s1;
		area_b_s2 <= wb_s1 * hb_s1;
		uni_s3    <= UW'(area_a_s2) + UW'(area_b_s2) - UW'(inter_s2);
		inter_s3  <= UW'(inter_s2);
		hit       <= (uni_s3 > 0) && (lhs > rhs);
	end

	assign lhs = CMPW'(inter_s3) <<< LIMIT_W;
	assign rhs = CMPW'($signed({1'b0, limit}) * uni_s3);

endmodule

// File: rtl/per_class_box_nms.sv
// per_class_box_nms: top level, batch loader, score sort, greedy suppression and output sequencer
// depends on pcnms_pkg, pcnms_ram, pcnms_iou
// throughput: one box per cycle while loading; after the last box the stored boxes are sorted,
// then suppressed anchor by anchor with one iou test per box pair (4-stage iou pipe), then the
// kept boxes are emitted and the suppressed ones skipped; one batch at a time
// reset: async active low; clears the batch count, overflow mark and fsm, iou_limit to 19661
module per_class_box_nms
	import pcnms_pkg::*;
#(
	parameter int MAX_BOXES   = 64,
	parameter int NUM_CLASSES = 20,
	parameter int COORD_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         iou_limit_we,
	input  logic [LIMIT_W-1:0]           iou_limit_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [SCORE_W-1:0]           score,
	input  logic [CLASS_W-1:0]           class_id,
	input  logic signed [COORD_BITS-1:0] box_left,
	input  logic signed [COORD_BITS-1:0] box_top,
	input  logic signed [COORD_BITS-1:0] box_right,
	input  logic signed [COORD_BITS-1:0] box_bottom,
	input  logic                         last_box,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [SCORE_W-1:0]           out_score,
	output logic [CLASS_W-1:0]           out_class,
	output logic signed [COORD_BITS-1:0] out_left,
	output logic signed [COORD_BITS-1:0] out_top,
	output logic signed [COORD_BITS-1:0] out_right,
	output logic signed [COORD_BITS-1:0] out_bottom,
	output logic [KIDX_W-1:0]            kept_index,
	output logic                         last_kept,
	output logic                         overflow
);

	localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNTW = AW + 1;
	localparam int SCW  = SCORE_W + CLASS_W;
	localparam int BW   = 4 * COORD_BITS;
	localparam int KW   = CLASS_W + SCORE_W + AW;

	state_t state_q, state_d;

	// batch bookkeeping
	logic [LIMIT_W-1:0] limit_q;
	logic [CNTW-1:0]    cnt_q;
	logic               ovf_q;
	logic [CNTW-1:0]    k_q, e_q, i_q, j_q, kept_q, emit_q;

	// sort scan: best key so far and key picked at the previous position
	logic          scan_v_s1;
	logic [AW-1:0] scan_idx_s1;
	logic [KW-1:0] best_key_q, prev_key_q, scan_key;
	logic          best_v_q, prev_v_q, scan_take;

	// anchor box of the current suppression pass
	logic [BW-1:0]      a_box_q;
	logic [CLASS_W-1:0] a_cls_q;

	// rams
	logic            box_we, ord_we, sup_we;
	logic [AW-1:0]   box_raddr, ord_raddr, ord_waddr;
	logic [BW-1:0]   coord_rd;
	logic [SCW-1:0]  sc_rd;
	logic [AW-1:0]   ord_rd;
	logic            sup_rd, sup_wdata;

	logic in_acc, cls_ok, room, iou_start, iou_done, iou_hit, emit_last;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT_OUT);
	assign in_acc    = in_valid && in_ready;
	assign cls_ok    = ({1'b0, class_id} < (CLASS_W + 1)'(NUM_CLASSES));
	assign room      = (cnt_q < CNTW'(MAX_BOXES));
	assign box_we    = in_acc && cls_ok && room;

	// reads: scan walks entries directly, the other phases go through the order table
	assign box_raddr = (state_q == ST_SORT_SCAN) ? e_q[AW-1:0] : ord_rd;
	assign ord_raddr = (state_q == ST_J_READ) ? j_q[AW-1:0] : i_q[AW-1:0];
	assign ord_we    = (state_q == ST_SORT_WRITE);
	assign ord_waddr = (state_q == ST_SORT_WRITE) ? k_q[AW-1:0] : j_q[AW-1:0];
	assign sup_we    = ord_we || (state_q == ST_IOU_WAIT && iou_done && iou_hit);
	assign sup_wdata = !ord_we;

	// sort key: class ascending, score descending, arrival ascending (unique per entry)
	assign scan_key  = {sc_rd[SCW-1:SCORE_W], ~sc_rd[SCORE_W-1:0], scan_idx_s1};
	assign scan_take = scan_v_s1 && (!prev_v_q || scan_key > prev_key_q)
		&& (!best_v_q || scan_key < best_key_q);

	assign iou_start = (state_q == ST_B_TEST) && (sc_rd[SCW-1:SCORE_W] == a_cls_q);
	assign emit_last = (CNTW'(emit_q + CNTW'(1)) == kept_q);

	pcnms_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_coord_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({box_bottom, box_right, box_top, box_left}),
		.raddr (box_raddr),
		.rdata (coord_rd)
	);

	pcnms_ram #(.WIDTH(SCW), .DEPTH(MAX_BOXES)) u_sc_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({class_id, score}),
		.raddr (box_raddr),
		.rdata (sc_rd)
	);

	pcnms_ram #(.WIDTH(AW), .DEPTH(MAX_BOXES)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (k_q[AW-1:0]),
		.wdata (best_key_q[AW-1:0]),
		.raddr (ord_raddr),
		.rdata (ord_rd)
	);

	// suppression flags by sorted position, cleared as each position is written by the sort
	pcnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_sup_ram (
		.clk   (clk),
		.we    (sup_we),
		.waddr (ord_waddr),
		.wdata (sup_wdata),
		.raddr (ord_raddr),
		.rdata (sup_rd)
	);

	pcnms_iou #(.CW(COORD_BITS)) u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (iou_start),
		.limit  (limit_q),
		.box_a  (a_box_q),
		.box_b  (coord_rd),
		.done   (iou_done),
		.hit    (iou_hit)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && last_box) state_d = ST_SORT_INIT;
			end
			ST_SORT_INIT: begin
				state_d = (cnt_q == '0) ? ST_I_READ : ST_SORT_SCAN;
			end
			ST_SORT_SCAN: begin
				if (e_q == cnt_q && !scan_v_s1) state_d = ST_SORT_WRITE;
			end
			ST_SORT_WRITE: begin
				state_d = (CNTW'(k_q + CNTW'(1)) == cnt_q) ? ST_I_READ : ST_SORT_SCAN;
			end
			ST_I_READ: begin
				if (i_q != cnt_q) state_d = ST_I_CHECK;
				else if (kept_q == '0) state_d = ST_LOAD;
				else state_d = ST_EMIT_READ;
			end
			ST_I_CHECK: begin
				state_d = sup_rd ? ST_I_READ : ST_A_WAIT;
			end
			ST_A_WAIT: begin
				state_d = ST_J_READ;
			end
			ST_J_READ: begin
				state_d = (j_q == cnt_q) ? ST_I_READ : ST_J_CHECK;
			end
			ST_J_CHECK: begin
				state_d = sup_rd ? ST_J_READ : ST_B_TEST;
			end
			ST_B_TEST: begin
				// sorted by class, so a class change ends this anchor's pass
				state_d = iou_start ? ST_IOU_WAIT : ST_I_READ;
			end
			ST_IOU_WAIT: begin
				if (iou_done) state_d = ST_J_READ;
			end
			ST_EMIT_READ: begin
				state_d = (i_q == cnt_q) ? ST_LOAD : ST_EMIT_IDX;
			end
			ST_EMIT_IDX: begin
				state_d = sup_rd ? ST_EMIT_READ : ST_EMIT_BOX;
			end
			ST_EMIT_BOX: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_ready) state_d = last_kept ? ST_LOAD : ST_EMIT_READ;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			limit_q   <= LIMIT_RESET;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			scan_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			if (iou_limit_we) limit_q <= iou_limit_wdata;
			scan_v_s1 <= (state_q == ST_SORT_SCAN) && (e_q != cnt_q);
			if (box_we) cnt_q <= CNTW'(cnt_q + CNTW'(1));
			if (in_acc && cls_ok && !room) ovf_q <= 1'b1;
			// batch done: drop stored boxes and the overflow mark
			if (state_q != ST_LOAD && state_d == ST_LOAD) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// datapath counters and payload registers
	always_ff @(posedge clk) begin
		scan_idx_s1 <= e_q[AW-1:0];
		if (scan_take) begin
			best_key_q <= scan_key;
			best_v_q   <= 1'b1;
		end
		case (state_q)
			ST_SORT_INIT: begin
				k_q      <= '0;
				e_q      <= '0;
				i_q      <= '0;
				kept_q   <= '0;
				prev_v_q <= 1'b0;
				best_v_q <= 1'b0;
			end
			ST_SORT_SCAN: begin
				if (e_q != cnt_q) e_q <= CNTW'(e_q + CNTW'(1));
			end
			ST_SORT_WRITE: begin
				prev_key_q <= best_key_q;
				prev_v_q   <= 1'b1;
				best_v_q   <= 1'b0;
				k_q        <= CNTW'(k_q + CNTW'(1));
				e_q        <= '0;
				i_q        <= '0;
				kept_q     <= '0;
			end
			ST_I_READ: begin
				emit_q <= '0;
				if (i_q == cnt_q) i_q <= '0;
			end
			ST_I_CHECK: begin
				if (sup_rd) begin
					i_q <= CNTW'(i_q + CNTW'(1));
				end else begin
					kept_q <= CNTW'(kept_q + CNTW'(1));
					j_q    <= CNTW'(i_q + CNTW'(1));
				end
			end
			ST_A_WAIT: begin
				a_box_q <= coord_rd;
				a_cls_q <= sc_rd[SCW-1:SCORE_W];
			end
			ST_J_READ: begin
				if (j_q == cnt_q) i_q <= CNTW'(i_q + CNTW'(1));
			end
			ST_J_CHECK: begin
				if (sup_rd) j_q <= CNTW'(j_q + CNTW'(1));
			end
			ST_B_TEST: begin
				if (!iou_start) i_q <= CNTW'(i_q + CNTW'(1));
			end
			ST_IOU_WAIT: begin
				if (iou_done) j_q <= CNTW'(j_q + CNTW'(1));
			end
			ST_EMIT_IDX: begin
				if (sup_rd) i_q <= CNTW'(i_q + CNTW'(1));
			end
			ST_EMIT_BOX: begin
				out_score  <= sc_rd[SCORE_W-1:0];
				out_class  <= sc_rd[SCW-1:SCORE_W];
				out_left   <= coord_rd[COORD_BITS-1:0];
				out_top    <= coord_rd[2*COORD_BITS-1:COORD_BITS];
				out_right  <= coord_rd[3*COORD_BITS-1:2*COORD_BITS];
				out_bottom <= coord_rd[4*COORD_BITS-1:3*COORD_BITS];
				kept_index <= KIDX_W'(emit_q);
				last_kept  <= emit_last;
				overflow   <= ovf_q;
			end
			ST_EMIT_OUT: begin
				if (out_ready) begin
					emit_q <= CNTW'(emit_q + CNTW'(1));
					i_q    <= CNTW'(i_q + CNTW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	// loading and emitting never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid both high");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_BOXES))
		else $error("box count beyond capacity");

	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_kept) |=> (cnt_q == '0 && !ovf_q))
		else $error("batch state not cleared after final kept item");

	a_iou_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		iou_done |-> (state_q == ST_IOU_WAIT))
		else $error("iou result outside wait state");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (emit_q < kept_q))
		else $error("emitting more items than were kept");

endmodule
